FILE: rtl/core/cmt_pkg.sv
// ----------------------------------------------------------------------------
// cmt_pkg
// shared types and constants of the cluster membership table
// ----------------------------------------------------------------------------
package cmt_pkg;

    localparam int MAX_VERTICES = 256;
    localparam int IDX_W        = 8;
    localparam int CNT_W        = 9;

    localparam logic [CNT_W-1:0] MEMBERS_MAX  = 9'd511;
    localparam logic [CNT_W-1:0] TABLE_LIMIT  = 9'd256;
    localparam logic [CNT_W-1:0] NV_RESET     = 9'd256;

    localparam logic [1:0] OP_NEW    = 2'd0;
    localparam logic [1:0] OP_ADD    = 2'd1;
    localparam logic [1:0] OP_REMOVE = 2'd2;
    localparam logic [1:0] OP_UNUSED = 2'd3;

    localparam logic [1:0] STATUS_OK    = 2'd0;
    localparam logic [1:0] STATUS_RANGE = 2'd1;
    localparam logic [1:0] STATUS_FULL  = 2'd2;

    typedef struct packed {
        logic clear;
        logic load;
    } trk_ctl_t;

endpackage

FILE: rtl/core/cluster_membership_table_unit.sv
// ----------------------------------------------------------------------------
// cluster_membership_table_unit
// partition of vertices into densely numbered clusters with member counts
// ----------------------------------------------------------------------------
// an operation (op, vertex, cluster) is taken on a cycle with start high and
// busy low; busy stays high while it is worked on. its one result appears on
// status, cluster_index, cluster_count, biggest_cluster and biggest_size for
// exactly one cycle with result_valid high; the receiver cannot hold it off.
// the num_vertices register is written over cfg_valid/cfg_ready; the user
// must write it only while idle, which the block does not enforce. all work
// goes through one read/compare/update path sweeping the two tables, one
// entry per cycle through their registered-read memory ports:
//   rejected op, new cluster         : final scan of the counts
//   add, remove without deletion     : count update, then final scan
//   remove that deletes cluster K    : update, shift of the counts above K,
//                                      label renumbering, final scan
// the label renumbering sweep runs over all vertices.
// busy drops in the cycle that shows the result, so the next op can be
// taken at the end of that cycle.
// reset empties the table: no clusters, all vertices unassigned, and
// num_vertices back to 256.
// ----------------------------------------------------------------------------
module cluster_membership_table_unit (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    output logic                        busy,
    input  logic [1:0]                  op,
    input  logic [cmt_pkg::IDX_W-1:0]   vertex,
    input  logic [cmt_pkg::IDX_W-1:0]   cluster,
    input  logic                        cfg_valid,
    output logic                        cfg_ready,
    input  logic [cmt_pkg::CNT_W-1:0]   num_vertices,
    output logic                        result_valid,
    output logic [1:0]                  status,
    output logic [cmt_pkg::IDX_W-1:0]   cluster_index,
    output logic [cmt_pkg::CNT_W-1:0]   cluster_count,
    output logic [cmt_pkg::IDX_W-1:0]   biggest_cluster,
    output logic [cmt_pkg::CNT_W-1:0]   biggest_size
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_UPDATE,
        S_SHIFT,
        S_RENUM,
        S_SCAN
    } state_t;

    state_t                    state_reg;
    logic [1:0]                op_reg;
    logic [cmt_pkg::IDX_W-1:0] cluster_reg;
    logic [cmt_pkg::CNT_W-1:0] live_reg;
    logic [cmt_pkg::CNT_W-1:0] idx_reg;
    logic                      pend_reg;
    logic [cmt_pkg::IDX_W-1:0] pend_addr_reg;
    logic [1:0]                status_reg;
    logic [cmt_pkg::IDX_W-1:0] cidx_reg;
    logic [cmt_pkg::CNT_W-1:0] nv_reg;
    logic [cmt_pkg::MAX_VERTICES-1:0] assigned_reg;
    logic                      strobe_reg;
    logic [1:0]                out_status_reg;
    logic [cmt_pkg::IDX_W-1:0] out_cidx_reg;
    logic [cmt_pkg::CNT_W-1:0] out_count_reg;
    logic [cmt_pkg::IDX_W-1:0] out_best_reg;
    logic [cmt_pkg::CNT_W-1:0] out_size_reg;

    logic [cmt_pkg::CNT_W-1:0] n_eff;
    logic                      accept;
    logic                      in_bad;
    logic                      full;
    logic                      k_bad;
    logic                      idx_lt_live;
    logic                      idx_lt_max;

    logic                      mem_wr_en;
    logic [cmt_pkg::IDX_W-1:0] mem_wr_addr;
    logic [cmt_pkg::CNT_W-1:0] mem_wr_data;
    logic                      mem_rd_en;
    logic [cmt_pkg::IDX_W-1:0] mem_rd_addr;
    logic [cmt_pkg::CNT_W-1:0] mem_rd_data;

    logic                      lab_wr_en;
    logic [cmt_pkg::IDX_W-1:0] lab_wr_addr;
    logic [cmt_pkg::IDX_W-1:0] lab_wr_data;
    logic                      lab_rd_en;
    logic [cmt_pkg::IDX_W-1:0] lab_rd_addr;
    logic [cmt_pkg::IDX_W-1:0] lab_rd_data;

    cmt_pkg::trk_ctl_t         trk_ctl;
    logic [cmt_pkg::IDX_W-1:0] trk_best;
    logic [cmt_pkg::CNT_W-1:0] trk_size;

    assign busy      = (state_reg != S_IDLE);
    assign cfg_ready = 1'b1;
    assign accept    = start && !busy;

    assign n_eff       = (nv_reg > cmt_pkg::TABLE_LIMIT) ? cmt_pkg::TABLE_LIMIT : nv_reg;
    assign in_bad      = (op == cmt_pkg::OP_UNUSED) || ({1'b0, vertex} >= n_eff);
    assign full        = (live_reg == cmt_pkg::TABLE_LIMIT);
    assign k_bad       = ({1'b0, cluster} >= live_reg);
    assign idx_lt_live = (idx_reg < live_reg);
    assign idx_lt_max  = (idx_reg < cmt_pkg::TABLE_LIMIT);

    // member count memory port
    always_comb
    begin
        mem_wr_en   = 1'b0;
        mem_wr_addr = '0;
        mem_wr_data = '0;
        mem_rd_en   = 1'b0;
        mem_rd_addr = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept && !in_bad)
                begin
                    if (op == cmt_pkg::OP_NEW)
                    begin
                        mem_wr_en   = !full;
                        mem_wr_addr = live_reg[cmt_pkg::IDX_W-1:0];
                        mem_wr_data = 9'd1;
                    end
                    else
                    begin
                        mem_rd_en   = !k_bad;
                        mem_rd_addr = cluster;
                    end
                end
            end
            S_UPDATE:
            begin
                mem_wr_addr = cluster_reg;
                if (op_reg == cmt_pkg::OP_ADD)
                begin
                    mem_wr_en   = 1'b1;
                    mem_wr_data = (mem_rd_data < cmt_pkg::MEMBERS_MAX)
                                  ? mem_rd_data + 9'd1 : mem_rd_data;
                end
                else
                begin
                    mem_wr_en   = (mem_rd_data > 9'd1);
                    mem_wr_data = mem_rd_data - 9'd1;
                end
            end
            S_SHIFT:
            begin
                mem_rd_en   = idx_lt_live;
                mem_rd_addr = idx_reg[cmt_pkg::IDX_W-1:0];
                mem_wr_en   = pend_reg;
                mem_wr_addr = pend_addr_reg - 8'd1;
                mem_wr_data = mem_rd_data;
            end
            S_SCAN:
            begin
                mem_rd_en   = idx_lt_live;
                mem_rd_addr = idx_reg[cmt_pkg::IDX_W-1:0];
            end
            S_RENUM:
            begin
                mem_rd_en = 1'b0;
            end
            default:
            begin
                mem_rd_en = 1'b0;
            end
        endcase
    end

    // vertex label memory port
    always_comb
    begin
        lab_wr_en   = 1'b0;
        lab_wr_addr = vertex;
        lab_wr_data = '0;
        lab_rd_en   = 1'b0;
        lab_rd_addr = idx_reg[cmt_pkg::IDX_W-1:0];
        if (state_reg == S_IDLE)
        begin
            if (accept && !in_bad && op == cmt_pkg::OP_NEW)
            begin
                lab_wr_en   = !full;
                lab_wr_data = live_reg[cmt_pkg::IDX_W-1:0];
            end
            else if (accept && !in_bad && op == cmt_pkg::OP_ADD)
            begin
                lab_wr_en   = !k_bad;
                lab_wr_data = cluster;
            end
        end
        else if (state_reg == S_RENUM)
        begin
            lab_rd_en   = idx_lt_max;
            lab_wr_addr = pend_addr_reg;
            lab_wr_data = lab_rd_data - 8'd1;
            lab_wr_en   = pend_reg && assigned_reg[pend_addr_reg]
                          && (lab_rd_data > cluster_reg);
        end
    end

    assign trk_ctl.clear = accept;
    assign trk_ctl.load  = (state_reg == S_SCAN) && pend_reg;

    cmt_ram #(
        .WIDTH (cmt_pkg::CNT_W),
        .DEPTH (cmt_pkg::MAX_VERTICES)
    ) u_members (
        .clk     (clk),
        .wr_en   (mem_wr_en),
        .wr_addr (mem_wr_addr),
        .wr_data (mem_wr_data),
        .rd_en   (mem_rd_en),
        .rd_addr (mem_rd_addr),
        .rd_data (mem_rd_data)
    );

    cmt_ram #(
        .WIDTH (cmt_pkg::IDX_W),
        .DEPTH (cmt_pkg::MAX_VERTICES)
    ) u_labels (
        .clk     (clk),
        .wr_en   (lab_wr_en),
        .wr_addr (lab_wr_addr),
        .wr_data (lab_wr_data),
        .rd_en   (lab_rd_en),
        .rd_addr (lab_rd_addr),
        .rd_data (lab_rd_data)
    );

    cmt_best_tracker u_tracker (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctl       (trk_ctl),
        .idx       (pend_addr_reg),
        .size      (mem_rd_data),
        .best      (trk_best),
        .best_size (trk_size)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            op_reg         <= cmt_pkg::OP_NEW;
            cluster_reg    <= '0;
            live_reg       <= '0;
            idx_reg        <= '0;
            pend_reg       <= 1'b0;
            pend_addr_reg  <= '0;
            status_reg     <= cmt_pkg::STATUS_OK;
            cidx_reg       <= '0;
            nv_reg         <= cmt_pkg::NV_RESET;
            assigned_reg   <= '0;
            strobe_reg     <= 1'b0;
            out_status_reg <= cmt_pkg::STATUS_OK;
            out_cidx_reg   <= '0;
            out_count_reg  <= '0;
            out_best_reg   <= '0;
            out_size_reg   <= '0;
        end
        else
        begin
            strobe_reg <= 1'b0;
            if (cfg_valid && cfg_ready)
            begin
                nv_reg <= num_vertices;
            end
            unique case (state_reg)
                S_IDLE:
                begin
                    if (accept)
                    begin
                        op_reg      <= op;
                        cluster_reg <= cluster;
                        pend_reg    <= 1'b0;
                        idx_reg     <= '0;
                        cidx_reg    <= '0;
                        status_reg  <= cmt_pkg::STATUS_OK;
                        state_reg   <= S_SCAN;
                        priority if (in_bad)
                        begin
                            status_reg <= cmt_pkg::STATUS_RANGE;
                        end
                        else if (op == cmt_pkg::OP_NEW)
                        begin
                            if (full)
                            begin
                                status_reg <= cmt_pkg::STATUS_FULL;
                            end
                            else
                            begin
                                cidx_reg             <= live_reg[cmt_pkg::IDX_W-1:0];
                                live_reg             <= live_reg + 9'd1;
                                assigned_reg[vertex] <= 1'b1;
                            end
                        end
                        else if (k_bad)
                        begin
                            status_reg <= cmt_pkg::STATUS_RANGE;
                        end
                        else if (op == cmt_pkg::OP_ADD)
                        begin
                            cidx_reg             <= cluster;
                            assigned_reg[vertex] <= 1'b1;
                            state_reg            <= S_UPDATE;
                        end
                        else
                        begin
                            assigned_reg[vertex] <= 1'b0;
                            state_reg            <= S_UPDATE;
                        end
                    end
                end
                S_UPDATE:
                begin
                    if (op_reg == cmt_pkg::OP_REMOVE && mem_rd_data <= 9'd1)
                    begin
                        idx_reg   <= {1'b0, cluster_reg} + 9'd1;
                        state_reg <= S_SHIFT;
                    end
                    else
                    begin
                        idx_reg   <= '0;
                        state_reg <= S_SCAN;
                    end
                end
                S_SHIFT:
                begin
                    pend_reg      <= idx_lt_live;
                    pend_addr_reg <= idx_reg[cmt_pkg::IDX_W-1:0];
                    if (idx_lt_live)
                    begin
                        idx_reg <= idx_reg + 9'd1;
                    end
                    else if (!pend_reg)
                    begin
                        live_reg  <= live_reg - 9'd1;
                        idx_reg   <= '0;
                        state_reg <= S_RENUM;
                    end
                end
                S_RENUM:
                begin
                    pend_reg      <= idx_lt_max;
                    pend_addr_reg <= idx_reg[cmt_pkg::IDX_W-1:0];
                    if (idx_lt_max)
                    begin
                        idx_reg <= idx_reg + 9'd1;
                    end
                    else if (!pend_reg)
                    begin
                        idx_reg   <= '0;
                        state_reg <= S_SCAN;
                    end
                end
                S_SCAN:
                begin
                    pend_reg      <= idx_lt_live;
                    pend_addr_reg <= idx_reg[cmt_pkg::IDX_W-1:0];
                    if (idx_lt_live)
                    begin
                        idx_reg <= idx_reg + 9'd1;
                    end
                    else if (!pend_reg)
                    begin
                        strobe_reg     <= 1'b1;
                        out_status_reg <= status_reg;
                        out_cidx_reg   <= cidx_reg;
                        out_count_reg  <= live_reg;
                        out_best_reg   <= trk_best;
                        out_size_reg   <= trk_size;
                        state_reg      <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign result_valid    = strobe_reg;
    assign status          = out_status_reg;
    assign cluster_index   = out_cidx_reg;
    assign cluster_count   = out_count_reg;
    assign biggest_cluster = out_best_reg;
    assign biggest_size    = out_size_reg;

endmodule

FILE: rtl/core/cmt_ram.sv
// ----------------------------------------------------------------------------
// cmt_ram
// generic single write port, single read port ram with registered read
// ----------------------------------------------------------------------------
module cmt_ram #(
    parameter int WIDTH = 9,
    parameter int DEPTH = 256,
    localparam int AW = $clog2(DEPTH)
) (
    input  logic             clk,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  logic [WIDTH-1:0] wr_data,
    input  logic             rd_en,
    input  logic [AW-1:0]    rd_addr,
    output logic [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

FILE: rtl/core/cmt_best_tracker.sv
// ----------------------------------------------------------------------------
// cmt_best_tracker
// running compare that keeps the lowest-index largest cluster of a scan
// ----------------------------------------------------------------------------
module cmt_best_tracker (
    input  logic                        clk,
    input  logic                        rst_n,
    input  cmt_pkg::trk_ctl_t           ctl,
    input  logic [cmt_pkg::IDX_W-1:0]   idx,
    input  logic [cmt_pkg::CNT_W-1:0]   size,
    output logic [cmt_pkg::IDX_W-1:0]   best,
    output logic [cmt_pkg::CNT_W-1:0]   best_size
);

    logic [cmt_pkg::IDX_W-1:0] best_reg;
    logic [cmt_pkg::CNT_W-1:0] best_size_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            best_reg      <= '0;
            best_size_reg <= '0;
        end
        else if (ctl.clear)
        begin
            best_reg      <= '0;
            best_size_reg <= '0;
        end
        else if (ctl.load && (idx == '0 || size > best_size_reg))
        begin
            best_reg      <= idx;
            best_size_reg <= size;
        end
    end

    assign best      = best_reg;
    assign best_size = best_size_reg;

endmodule

FILE: tb/sv/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// self-checking testbench of the cluster membership table unit
// ----------------------------------------------------------------------------
// drives new, add and remove operations through the start/busy port and
// predicts every result with a behavioral copy of the label and member
// tables. results are compared field by field in order of issue. covers
// rejected operations, the vertex limit register at its extremes, cluster
// deletion with renumbering, a full table, member count saturation
// and constrained random traffic, all with random idle gaps.
// ----------------------------------------------------------------------------
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int IDX_W          = cmt_pkg::IDX_W;
    localparam int CNT_W          = cmt_pkg::CNT_W;
    localparam int MAX_VERTICES   = cmt_pkg::MAX_VERTICES;
    localparam int WATCHDOG_LIMIT = 5000;
    localparam int DRAIN_CYCLES   = 800;
    localparam logic [CNT_W-1:0] UNASSIGNED = 9'd256;

    typedef struct packed {
        logic [1:0]       status;
        logic [IDX_W-1:0] cluster_index;
        logic [CNT_W-1:0] cluster_count;
        logic [IDX_W-1:0] biggest_cluster;
        logic [CNT_W-1:0] biggest_size;
    } outcome_t;

    logic             clk          = 1'b0;
    logic             rst_n        = 1'b0;
    logic             start        = 1'b0;
    logic [1:0]       op           = cmt_pkg::OP_NEW;
    logic [IDX_W-1:0] vertex       = '0;
    logic [IDX_W-1:0] cluster      = '0;
    logic             cfg_valid    = 1'b0;
    logic [CNT_W-1:0] num_vertices = '0;
    logic             busy;
    logic             cfg_ready;
    logic             result_valid;
    logic [1:0]       status;
    logic [IDX_W-1:0] cluster_index;
    logic [CNT_W-1:0] cluster_count;
    logic [IDX_W-1:0] biggest_cluster;
    logic [CNT_W-1:0] biggest_size;

    logic [CNT_W-1:0] model_label   [MAX_VERTICES];
    logic [CNT_W-1:0] model_members [MAX_VERTICES];
    logic [CNT_W-1:0] model_live;
    logic [CNT_W-1:0] model_nv;

    outcome_t expected_outcomes [$];
    int       mismatch_count = 0;
    int       idle_cycles    = 0;
    bit       no_idle        = 1'b0;

    cluster_membership_table_unit dut (
        .clk             (clk),
        .rst_n           (rst_n),
        .start           (start),
        .busy            (busy),
        .op              (op),
        .vertex          (vertex),
        .cluster         (cluster),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .num_vertices    (num_vertices),
        .result_valid    (result_valid),
        .status          (status),
        .cluster_index   (cluster_index),
        .cluster_count   (cluster_count),
        .biggest_cluster (biggest_cluster),
        .biggest_size    (biggest_size)
    );

    always #10 clk = ~clk;

    function automatic int vertex_limit();
        return (model_nv > cmt_pkg::TABLE_LIMIT) ? MAX_VERTICES : int'(model_nv);
    endfunction

    function automatic outcome_t apply_membership_op(input logic [1:0] o,
                                                     input logic [IDX_W-1:0] v,
                                                     input logic [IDX_W-1:0] k);
        outcome_t res;
        int j;
        res = '0;
        if (o == cmt_pkg::OP_UNUSED || int'(v) >= vertex_limit())
        begin
            res.status = cmt_pkg::STATUS_RANGE;
        end
        else if (o == cmt_pkg::OP_NEW)
        begin
            if (model_live >= cmt_pkg::TABLE_LIMIT)
            begin
                res.status = cmt_pkg::STATUS_FULL;
            end
            else
            begin
                model_members[model_live[IDX_W-1:0]] = 9'd1;
                model_label[v] = model_live;
                res.cluster_index = model_live[IDX_W-1:0];
                model_live = model_live + 9'd1;
            end
        end
        else if ({1'b0, k} >= model_live)
        begin
            res.status = cmt_pkg::STATUS_RANGE;
        end
        else if (o == cmt_pkg::OP_ADD)
        begin
            model_label[v] = {1'b0, k};
            if (model_members[k] < cmt_pkg::MEMBERS_MAX)
                model_members[k] = model_members[k] + 9'd1;
            res.cluster_index = k;
        end
        else
        begin
            model_label[v] = UNASSIGNED;
            if (model_members[k] <= 9'd1)
            begin
                // delete the cluster: shift sizes down, renumber labels above it
                for (j = int'(k); j + 1 < int'(model_live); j++)
                    model_members[IDX_W'(j)] = model_members[IDX_W'(j + 1)];
                model_live = model_live - 9'd1;
                for (j = 0; j < MAX_VERTICES; j++)
                    if (model_label[IDX_W'(j)] != UNASSIGNED
                        && model_label[IDX_W'(j)] > {1'b0, k})
                        model_label[IDX_W'(j)] = model_label[IDX_W'(j)] - 9'd1;
            end
            else
            begin
                model_members[k] = model_members[k] - 9'd1;
            end
        end
        res.cluster_count = model_live;
        for (j = 0; j < int'(model_live); j++)
        begin
            if (j == 0 || model_members[IDX_W'(j)] > res.biggest_size)
            begin
                res.biggest_cluster = IDX_W'(j);
                res.biggest_size    = model_members[IDX_W'(j)];
            end
        end
        return res;
    endfunction

    function automatic int idle_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 85)
            return $urandom_range(1, 3);
        if (r < 96)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    task automatic issue_op(input logic [1:0] o, input logic [IDX_W-1:0] v,
                            input logic [IDX_W-1:0] k);
        int gap;
        start   <= 1'b1;
        op      <= o;
        vertex  <= v;
        cluster <= k;
        do
            @(posedge clk);
        while (busy);
        expected_outcomes = {expected_outcomes, apply_membership_op(o, v, k)};
        if ($urandom_range(0, 39) == 0)
            no_idle = ($urandom_range(0, 3) == 0);
        gap = no_idle ? 0 : idle_len();
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    task automatic write_num_vertices(input logic [CNT_W-1:0] val);
        start <= 1'b0;
        while (expected_outcomes.size() != 0)
            @(posedge clk);
        cfg_valid    <= 1'b1;
        num_vertices <= val;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        model_nv = val;
    endtask

    task automatic random_op(input int new_pct, input int add_pct, input int single_pct);
        logic [1:0] o;
        int r;
        int lim;
        int v;
        int k;
        int j;
        lim = vertex_limit();
        if ($urandom_range(0, 99) < 10 || lim == 0)
        begin
            o = 2'($urandom_range(0, 3));
            v = $urandom_range(0, 255);
            k = $urandom_range(0, 255);
        end
        else
        begin
            r = $urandom_range(0, 99);
            o = (r < new_pct) ? cmt_pkg::OP_NEW
                : (r < new_pct + add_pct) ? cmt_pkg::OP_ADD : cmt_pkg::OP_REMOVE;
            v = $urandom_range(0, lim - 1);
            if (o == cmt_pkg::OP_NEW || model_live == 0)
                k = $urandom_range(0, 255);
            else
                k = $urandom_range(0, model_live - 1);
            if (o == cmt_pkg::OP_REMOVE && $urandom_range(0, 99) < single_pct)
            begin
                for (j = 0; j < int'(model_live); j++)
                begin
                    if (model_members[IDX_W'(j)] == 9'd1)
                    begin
                        k = j;
                        break;
                    end
                end
            end
        end
        issue_op(o, IDX_W'(v), IDX_W'(k));
    endtask

    task automatic test_directed_ops();
        write_num_vertices(cmt_pkg::NV_RESET);
        issue_op(cmt_pkg::OP_UNUSED, 8'h00, 8'h00);
        issue_op(cmt_pkg::OP_ADD,    8'h00, 8'h00);
        issue_op(cmt_pkg::OP_REMOVE, 8'hFF, 8'h00);
        issue_op(cmt_pkg::OP_NEW,    8'h00, 8'hFF);
        issue_op(cmt_pkg::OP_NEW,    8'hFF, 8'h00);
        issue_op(cmt_pkg::OP_NEW,    8'h80, 8'hAA);
        issue_op(cmt_pkg::OP_ADD,    8'h01, 8'h02);
        issue_op(cmt_pkg::OP_ADD,    8'h02, 8'h02);
        issue_op(cmt_pkg::OP_ADD,    8'h7F, 8'hFF);
        issue_op(cmt_pkg::OP_ADD,    8'hFF, 8'h03);
        // reassign vertex 0 without leaving cluster 0
        issue_op(cmt_pkg::OP_ADD,    8'h00, 8'h01);
        // remove a vertex that is not a member
        issue_op(cmt_pkg::OP_REMOVE, 8'h55, 8'h01);
        issue_op(cmt_pkg::OP_REMOVE, 8'hFF, 8'h00);
        issue_op(cmt_pkg::OP_UNUSED, 8'hFF, 8'hFF);
        issue_op(cmt_pkg::OP_REMOVE, 8'hAA, 8'h00);
        issue_op(cmt_pkg::OP_REMOVE, 8'h00, 8'h00);
        issue_op(cmt_pkg::OP_REMOVE, 8'h01, 8'h00);
        issue_op(cmt_pkg::OP_REMOVE, 8'h02, 8'h00);
        issue_op(cmt_pkg::OP_NEW,    8'h33, 8'hCC);
    endtask

    task automatic test_vertex_limit();
        write_num_vertices(9'd1);
        issue_op(cmt_pkg::OP_NEW,    8'h00, 8'h00);
        issue_op(cmt_pkg::OP_NEW,    8'h01, 8'h00);
        issue_op(cmt_pkg::OP_ADD,    8'hFF, 8'h00);
        write_num_vertices(9'd0);
        issue_op(cmt_pkg::OP_NEW,    8'h00, 8'h00);
        issue_op(cmt_pkg::OP_REMOVE, 8'h00, 8'h00);
        write_num_vertices(9'd511);
        issue_op(cmt_pkg::OP_NEW,    8'hFF, 8'h00);
        write_num_vertices(9'd257);
        issue_op(cmt_pkg::OP_ADD,    8'hFF, 8'h00);
    endtask

    task automatic test_random_mix();
        int phase;
        int i;
        logic [CNT_W-1:0] nv_pick;
        for (phase = 0; phase < 4; phase++)
        begin
            case (phase)
                0:       nv_pick = CNT_W'($urandom_range(17, 255));
                1:       nv_pick = CNT_W'($urandom_range(1, 16));
                2:       nv_pick = CNT_W'($urandom_range(257, 511));
                default: nv_pick = cmt_pkg::TABLE_LIMIT;
            endcase
            write_num_vertices(nv_pick);
            for (i = 0; i < 220; i++)
            begin
                if (phase % 2 == 0)
                    random_op(55, 25, 0);
                else
                    random_op(15, 15, 60);
            end
        end
    endtask

    task automatic test_table_full();
        write_num_vertices(cmt_pkg::TABLE_LIMIT);
        while (model_live < cmt_pkg::TABLE_LIMIT)
            issue_op(cmt_pkg::OP_NEW, IDX_W'($urandom_range(0, 255)),
                     IDX_W'($urandom_range(0, 255)));
        issue_op(cmt_pkg::OP_NEW,    8'h00, 8'h00);
        issue_op(cmt_pkg::OP_NEW,    8'hFF, 8'hFF);
        issue_op(cmt_pkg::OP_ADD,    8'h10, 8'hFF);
        issue_op(cmt_pkg::OP_REMOVE, 8'h10, 8'hFF);
        issue_op(cmt_pkg::OP_REMOVE, 8'h11, 8'hFF);
        issue_op(cmt_pkg::OP_NEW,    8'h12, 8'h00);
    endtask

    task automatic test_count_saturation();
        logic [IDX_W-1:0] k;
        k = IDX_W'($urandom_range(0, model_live - 1));
        while (model_members[k] < cmt_pkg::MEMBERS_MAX)
            issue_op(cmt_pkg::OP_ADD, IDX_W'($urandom_range(0, 255)), k);
        repeat (3) issue_op(cmt_pkg::OP_ADD, IDX_W'($urandom_range(0, 255)), k);
        repeat (3) issue_op(cmt_pkg::OP_REMOVE, IDX_W'($urandom_range(0, 255)), k);
    endtask

    task automatic check_field(input string name, input int want, input int got);
        if (want != got)
        begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
            mismatch_count++;
        end
    endtask

    always @(posedge clk)
    begin
        outcome_t want;
        if (rst_n && result_valid)
        begin
            if (expected_outcomes.size() == 0)
            begin
                $display("%0t: unexpected transaction, status %0d count %0d",
                         $time, status, cluster_count);
                mismatch_count++;
            end
            else
            begin
                want = expected_outcomes.pop_front();
                check_field("status", int'(want.status), int'(status));
                check_field("cluster_index", int'(want.cluster_index),
                            int'(cluster_index));
                check_field("cluster_count", int'(want.cluster_count),
                            int'(cluster_count));
                check_field("biggest_cluster", int'(want.biggest_cluster),
                            int'(biggest_cluster));
                check_field("biggest_size", int'(want.biggest_size),
                            int'(biggest_size));
            end
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (start && !busy) || result_valid || (cfg_valid && cfg_ready))
        begin
            idle_cycles = 0;
        end
        else
        begin
            idle_cycles = idle_cycles + 1;
            if (idle_cycles >= WATCHDOG_LIMIT)
            begin
                $display("%0t: watchdog expired", $time);
                $display("*** FAILED ***");
                $finish;
            end
        end
    end

    initial
    begin
        foreach (model_label[j])
        begin
            model_label[j]   = UNASSIGNED;
            model_members[j] = '0;
        end
        model_live = '0;
        model_nv   = cmt_pkg::NV_RESET;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed_ops();
        test_vertex_limit();
        test_random_mix();
        test_table_full();
        test_count_saturation();

        start <= 1'b0;
        while (expected_outcomes.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatch_count == 0 && expected_outcomes.size() == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule

FILE: files.f
rtl/core/cmt_pkg.sv
rtl/core/cmt_ram.sv
rtl/core/cmt_best_tracker.sv
rtl/core/cluster_membership_table_unit.sv
tb/sv/tb_top.sv
